// ===== hdl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types and constants of the rotor speed ramp controller.
// ----------------------------------------------------------------------------
package rsr_pkg;

  // Widths of the drive and step values.
  localparam int unsigned DRIVE_W = 10;
  localparam int unsigned SUM_W   = DRIVE_W + 1;

  // Highest drive level; larger targets saturate to it.
  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 10'd1000;

  // Reset values of the step registers.
  localparam logic [DRIVE_W-1:0] RAMP_STEP_RST  = 10'd1;
  localparam logic [DRIVE_W-1:0] RUNUP_STEP_RST = 10'd20;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_MAIN  = 2'd0,
    OP_TAIL  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } rsr_op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RAMP_STEP  = 2'd0,
    REG_RUNUP_STEP = 2'd1,
    REG_SPARE2     = 2'd2,
    REG_SPARE3     = 2'd3
  } rsr_reg_t;

  // Operands of one channel update.
  typedef struct packed {
    logic [DRIVE_W-1:0] goal;
    logic [DRIVE_W-1:0] cur;
    logic [DRIVE_W-1:0] est;
    logic [DRIVE_W-1:0] ramp_step;
    logic [DRIVE_W-1:0] runup_step;
  } rsr_ramp_in_t;

  // Results of one channel update.
  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [DRIVE_W-1:0] est;
  } rsr_ramp_out_t;

endpackage

// ===== hdl/rsr_ramp.sv =====
// ----------------------------------------------------------------------------
// rsr_ramp
// One channel update: ramps the drive toward its goal and moves the shared
// speed estimate toward the new drive.
// ----------------------------------------------------------------------------
module rsr_ramp (
  input  rsr_pkg::rsr_ramp_in_t  ramp_in,
  output rsr_pkg::rsr_ramp_out_t ramp_out
);
  import rsr_pkg::*;

  logic [DRIVE_W-1:0] base;
  logic [SUM_W-1:0]   rise;
  logic [DRIVE_W-1:0] drive;
  logic [SUM_W-1:0]   est_up;
  logic [SUM_W-1:0]   drive_up;

  // Drive: below the goal it starts from the estimate at least, rises by the
  // ramp step and stops at the goal; otherwise it drops to the goal.
  always_comb begin
    base = (ramp_in.cur < ramp_in.est) ? ramp_in.est : ramp_in.cur;
    rise = {1'b0, base} + {1'b0, ramp_in.ramp_step};
    if (ramp_in.cur < ramp_in.goal) begin
      drive = (rise > {1'b0, ramp_in.goal}) ? ramp_in.goal : rise[DRIVE_W-1:0];
    end else begin
      drive = ramp_in.goal;
    end
  end

  // Estimate: moves toward the new drive by the runup step, never past it.
  always_comb begin
    est_up   = {1'b0, ramp_in.est} + {1'b0, ramp_in.runup_step};
    drive_up = {1'b0, drive} + {1'b0, ramp_in.runup_step};
    ramp_out.drive = drive;
    if (ramp_in.est < drive) begin
      ramp_out.est = (est_up < {1'b0, drive}) ? est_up[DRIVE_W-1:0] : drive;
    end else begin
      ramp_out.est = ({1'b0, ramp_in.est} > drive_up)
                     ? (ramp_in.est - ramp_in.runup_step) : drive;
    end
  end

endmodule

// ===== hdl/rotor_speed_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// rotor_speed_ramp_controller
// Soft-start ramp for a main and a tail rotor drive sharing one speed
// estimate, with a runup-complete flag driven by main-rotor updates.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   in_      slave      in_tvalid / in_tready   tuser: operation, tdata: target
//   out_     master     out_tvalid / out_tready tdata: drive, runup_complete
//   cfg_     slave      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item is captured in an input register, processed combinationally by the
// ramp logic and written to the output register; one item per cycle is
// sustained while the output is not stalled. The channel state registers
// (drive, estimate, flag) are written together with the output register. A
// stalled output holds both stages; the input stage still takes a transfer
// whenever it is empty or advancing. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module rotor_speed_ramp_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] target, [15:10] zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] drive, [10] runup_complete, [15:11] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import rsr_pkg::*;

  // Step registers.
  logic [DRIVE_W-1:0] ramp_step_r;
  logic [DRIVE_W-1:0] runup_step_r;

  // Input stage.
  logic               in_valid_r;
  rsr_op_t            op_r;
  logic [DRIVE_W-1:0] target_r;

  // Channel state.
  logic [DRIVE_W-1:0] main_drive_r, main_drive_nxt;
  logic [DRIVE_W-1:0] tail_drive_r, tail_drive_nxt;
  logic [DRIVE_W-1:0] est_r, est_nxt;
  logic               done_r, done_nxt;

  // Output stage.
  logic               out_valid_r;
  logic [DRIVE_W-1:0] drive_r, drive_nxt;
  logic               flag_r;

  logic               advance;
  logic               fire;
  logic [DRIVE_W-1:0] goal;
  logic               done_set;
  rsr_ramp_in_t       ramp_in;
  rsr_ramp_out_t      ramp_out;

  // Handshake: the input stage moves on when the output register is free.
  assign advance    = !out_valid_r || out_tready;
  assign fire       = in_valid_r && advance;
  assign in_tready  = !in_valid_r || advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, flag_r, drive_r};

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r  <= RAMP_STEP_RST;
      runup_step_r <= RUNUP_STEP_RST;
    end else if (cfg_valid) begin
      case (rsr_reg_t'(cfg_index))
        REG_RAMP_STEP:  ramp_step_r  <= cfg_data;
        REG_RUNUP_STEP: runup_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r     <= rsr_op_t'(in_tuser);
      target_r <= in_tdata[DRIVE_W-1:0];
    end
  end

  // Saturated goal and the shared ramp unit, fed by the selected channel.
  assign goal = (target_r > DRIVE_MAX) ? DRIVE_MAX : target_r;

  always_comb begin
    ramp_in.goal       = goal;
    ramp_in.cur        = (op_r == OP_TAIL) ? tail_drive_r : main_drive_r;
    ramp_in.est        = est_r;
    ramp_in.ramp_step  = ramp_step_r;
    ramp_in.runup_step = runup_step_r;
  end

  rsr_ramp u_ramp (
    .ramp_in  (ramp_in),
    .ramp_out (ramp_out)
  );

  // Next state and result of the item in the input stage.
  always_comb begin
    main_drive_nxt = main_drive_r;
    tail_drive_nxt = tail_drive_r;
    est_nxt        = est_r;
    done_nxt       = done_r;
    drive_nxt      = '0;
    done_set       = done_r || (goal != '0 && ramp_out.est >= goal);
    case (op_r)
      OP_MAIN: begin
        main_drive_nxt = ramp_out.drive;
        est_nxt        = ramp_out.est;
        drive_nxt      = ramp_out.drive;
        done_nxt       = done_set && !(goal == '0 && ramp_out.est == '0);
      end
      OP_TAIL: begin
        tail_drive_nxt = ramp_out.drive;
        est_nxt        = ramp_out.est;
        drive_nxt      = ramp_out.drive;
      end
      OP_RESET: begin
        main_drive_nxt = '0;
        tail_drive_nxt = '0;
        est_nxt        = '0;
      end
      default: ;
    endcase
  end

  // Channel state updates once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_drive_r <= '0;
      tail_drive_r <= '0;
      est_r        <= '0;
      done_r       <= 1'b0;
    end else if (fire) begin
      main_drive_r <= main_drive_nxt;
      tail_drive_r <= tail_drive_nxt;
      est_r        <= est_nxt;
      done_r       <= done_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      drive_r <= drive_nxt;
      flag_r  <= done_nxt;
    end
  end

  // The drives and the estimate never exceed the drive limit.
  a_state_limit: assert property (@(posedge clk) disable iff (!rst_n)
    main_drive_r <= DRIVE_MAX && tail_drive_r <= DRIVE_MAX && est_r <= DRIVE_MAX)
    else $error("drive or estimate above limit");

  // A processed reset operation leaves both drives and the estimate at zero.
  a_reset_op: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op_r == OP_RESET |=> main_drive_r == '0 && tail_drive_r == '0 && est_r == '0)
    else $error("reset operation did not clear the channel state");

  // The estimate, the main drive and the flag hold while no item is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(est_r) && $stable(main_drive_r) && $stable(done_r))
    else $error("channel state changed without a processed item");

  // A tail update never changes the runup flag.
  a_tail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && op_r == OP_TAIL |=> $stable(done_r))
    else $error("tail update changed the runup flag");

endmodule
